>>> rtl/core/sptxy_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sptxy_pkg: shared constants and helpers
// Field widths, the register map, the CORDIC gain and arctangent table, and the
// rounding and window test helpers of the polar-to-xy box filter.
// ----------------------------------------------------------------------------
package sptxy_pkg;

  localparam int RANGE_W  = 16;
  localparam int COORD_W  = 17;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int ATAN_IDX_W = 5;

  // Register map, index = byte address / 4.
  localparam logic [2:0] REG_START_ANGLE    = 3'd0;
  localparam logic [2:0] REG_ANGLE_STEP     = 3'd1;
  localparam logic [2:0] REG_RANGE_LOWER    = 3'd2;
  localparam logic [2:0] REG_RANGE_UPPER    = 3'd3;
  localparam logic [2:0] REG_FRONT_X_WINDOW = 3'd4;
  localparam logic [2:0] REG_FRONT_Y_WINDOW = 3'd5;
  localparam logic [2:0] REG_BACK_X_WINDOW  = 3'd6;
  localparam logic [2:0] REG_BACK_Y_WINDOW  = 3'd7;

  // CORDIC gain compensation 1/An in Q30.
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // Arctangent of 2^-i in units of 1/2^32 turn.
  function automatic logic [31:0] atan_turn32(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q16 value to millimetres: round half up, saturate to 17 bits signed.
  function automatic logic signed [COORD_W-1:0] to_mm(input logic signed [34:0] q);
    logic signed [35:0] sum;
    logic signed [19:0] mm;
    logic signed [COORD_W-1:0] res;
    sum = 36'(q) + 36'sd32768;
    mm  = sum[35:16];
    if (mm > 20'sd65535) begin
      res = 17'sd65535;
    end else if (mm < -20'sd65536) begin
      res = -17'sd65536;
    end else begin
      res = mm[COORD_W-1:0];
    end
    return res;
  endfunction

  // Inclusive window test; x is kept in [-x_up, -x_down], y in [y_down, y_up].
  function automatic logic box_hit(input logic signed [COORD_W-1:0] x,
                                   input logic signed [COORD_W-1:0] y,
                                   input logic [31:0] xwin,
                                   input logic [31:0] ywin);
    logic signed [17:0] xd, xu, yd, yu, xs, ys;
    xd = 18'($signed(xwin[15:0]));
    xu = 18'($signed(xwin[31:16]));
    yd = 18'($signed(ywin[15:0]));
    yu = 18'($signed(ywin[31:16]));
    xs = 18'(x);
    ys = 18'(y);
    return (xs >= -xu) && (xs <= -xd) && (ys >= yd) && (ys <= yu);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sptxy_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sptxy_if: sample and point channels
// Valid/ready channels carrying one range sample word and one point word.
// ----------------------------------------------------------------------------
interface sptxy_in_if;
  import sptxy_pkg::*;

  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic               nonfinite;
  logic               scan_start;

  modport source (output valid, output range_mm, output nonfinite, output scan_start,
                  input ready);
  modport sink   (input valid, input range_mm, input nonfinite, input scan_start,
                  output ready);
endinterface

interface sptxy_out_if;
  import sptxy_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_mm;
  logic                      point_valid;
  logic                      in_front_box;
  logic                      in_back_box;

  modport source (output valid, output x_mm, output y_mm, output point_valid,
                  output in_front_box, output in_back_box, input ready);
  modport sink   (input valid, input x_mm, input y_mm, input point_valid,
                  input in_front_box, input in_back_box, output ready);
endinterface
`default_nettype wire

>>> rtl/core/scan_polar_to_xy_box_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scan_polar_to_xy_box_filter: laser scan to cartesian points with box tests
// Tracks the beam angle, rotates each valid range sample into x and y with an
// iterative CORDIC and flags the points that fall in a front and a back box.
// ----------------------------------------------------------------------------
// Each word on in_chan is one range sample; each produces exactly one word on
// out_chan, in order. The block handles one sample at a time: in_chan.ready is
// high only while the sequencer is idle. A valid sample passes the accept
// step, one gain multiply, CORDIC_STEPS passes through the single shift-add
// rotation unit, one rounding step and one box test step. A sample that is
// non-finite or not strictly between the range limits skips the rotation and
// goes from the accept step straight to the box test step. The result sits
// in an output register, so the next sample is taken even if the consumer
// has not yet picked up the last point; only the box test step waits when
// that register is still full. Registers are to be written by the user
// through the APB-style port only while the block is idle; the block itself
// does not enforce this. Reads return the stored values.
// ----------------------------------------------------------------------------
module scan_polar_to_xy_box_filter #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  sptxy_in_if.sink                       in_chan,
  sptxy_out_if.source                    out_chan,
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [sptxy_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [sptxy_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [sptxy_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import sptxy_pkg::*;

  localparam int STEP_W   = $clog2(CORDIC_STEPS);
  localparam int A32_PAD  = 32 - ANGLE_BITS;
  localparam int PROD_W   = RANGE_W + 30;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_GAIN  = 5'b00010,
    S_ROT   = 5'b00100,
    S_ROUND = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Configuration registers.
  logic [15:0] start_angle_r, angle_step_r, range_lower_r, range_upper_r;
  logic [31:0] front_x_r, front_y_r, back_x_r, back_y_r;

  // Sequencer and datapath registers.
  state_t                     state_r, state_nxt;
  logic [ANGLE_BITS-1:0]      beam_r;
  logic [ANGLE_BITS-1:0]      angle_r;
  logic [RANGE_W-1:0]         range_r;
  logic                       valid_r;
  logic [STEP_W-1:0]          cnt_r;
  logic signed [34:0]         x_r, y_r;
  logic signed [32:0]         z_r;
  logic signed [COORD_W-1:0]  xo_r, yo_r;

  // Output register.
  logic                       out_valid_r;
  logic signed [COORD_W-1:0]  out_x_r, out_y_r;
  logic                       out_pv_r, out_front_r, out_back_r;

  logic                       in_fire;
  logic                       out_free;
  logic                       cfg_wr;
  logic [2:0]                 cfg_idx;
  logic [ANGLE_BITS-1:0]      angle_sel;
  logic                       sample_ok;
  logic [PROD_W-1:0]          prod;
  logic [31:0]                a32;
  logic signed [34:0]         dx, dy;
  logic signed [32:0]         atan_s;
  logic signed [34:0]         xq, yq;

  // --------------------------------------------------------------------------
  // Configuration port. pready is tied high; a write lands at the access cycle.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      range_lower_r <= '0;
      range_upper_r <= 16'hFFFF;
      front_x_r     <= '0;
      front_y_r     <= '0;
      back_x_r      <= '0;
      back_y_r      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START_ANGLE:    start_angle_r <= cfg_pwdata[15:0];
        REG_ANGLE_STEP:     angle_step_r  <= cfg_pwdata[15:0];
        REG_RANGE_LOWER:    range_lower_r <= cfg_pwdata[15:0];
        REG_RANGE_UPPER:    range_upper_r <= cfg_pwdata[15:0];
        REG_FRONT_X_WINDOW: front_x_r     <= cfg_pwdata;
        REG_FRONT_Y_WINDOW: front_y_r     <= cfg_pwdata;
        REG_BACK_X_WINDOW:  back_x_r      <= cfg_pwdata;
        REG_BACK_Y_WINDOW:  back_y_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_ANGLE:    cfg_prdata = 32'(start_angle_r);
      REG_ANGLE_STEP:     cfg_prdata = 32'(angle_step_r);
      REG_RANGE_LOWER:    cfg_prdata = 32'(range_lower_r);
      REG_RANGE_UPPER:    cfg_prdata = 32'(range_upper_r);
      REG_FRONT_X_WINDOW: cfg_prdata = front_x_r;
      REG_FRONT_Y_WINDOW: cfg_prdata = front_y_r;
      REG_BACK_X_WINDOW:  cfg_prdata = back_x_r;
      REG_BACK_Y_WINDOW:  cfg_prdata = back_y_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side: a word is taken only when the sequencer is idle. The beam angle
  // advances on every accepted word, valid or not; a scan start reloads it.
  // --------------------------------------------------------------------------
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign angle_sel = in_chan.scan_start ? ANGLE_BITS'(start_angle_r) : beam_r;
  assign sample_ok = !in_chan.nonfinite && (in_chan.range_mm > range_lower_r) &&
                     (in_chan.range_mm < range_upper_r);

  // The angle is scaled to 32 bits per turn: the top two bits are the quadrant,
  // the rest is the residual handed to the rotation.
  assign a32 = {angle_r, {A32_PAD{1'b0}}};

  // Range times the gain compensation in Q30; x takes it with 16 fraction bits.
  assign prod = PROD_W'(range_r) * PROD_W'(GAIN_Q30);

  // One CORDIC micro-rotation per cycle; the shifts floor toward minus infinity.
  assign dx     = y_r >>> cnt_r;
  assign dy     = x_r >>> cnt_r;
  assign atan_s = $signed({1'b0, atan_turn32(ATAN_IDX_W'(cnt_r))});

  // Exact quarter-turn fix-up for the quadrant.
  always_comb begin
    case (a32[31:30])
      QUAD_1:  begin xq = -y_r; yq = x_r;  end
      QUAD_2:  begin xq = -x_r; yq = -y_r; end
      QUAD_3:  begin xq = y_r;  yq = -x_r; end
      QUAD_0:  begin xq = x_r;  yq = y_r;  end
      default: begin xq = x_r;  yq = y_r;  end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = sample_ok ? S_GAIN : S_OUT;
      S_GAIN:  state_nxt = S_ROT;
      S_ROT:   if (cnt_r == LAST_STEP) state_nxt = S_ROUND;
      S_ROUND: state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      beam_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        beam_r <= angle_sel + ANGLE_BITS'(angle_step_r);
      end
      if (state_r == S_ROT) begin
        cnt_r <= (cnt_r == LAST_STEP) ? '0 : cnt_r + 1'b1;
      end
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      angle_r <= angle_sel;
      range_r <= in_chan.range_mm;
      valid_r <= sample_ok;
    end
    case (state_r)
      S_GAIN: begin
        x_r <= $signed(35'(prod[PROD_W-1:14]));
        y_r <= '0;
        z_r <= $signed({3'b000, a32[29:0]});
      end
      S_ROT: begin
        if (!z_r[32]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_s;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_s;
        end
      end
      S_ROUND: begin
        xo_r <= to_mm(xq);
        yo_r <= to_mm(yq);
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register: box tests are folded into the load. An invalid sample
  // leaves zero coordinates and clear box flags.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_pv_r <= valid_r;
      if (valid_r) begin
        out_x_r     <= xo_r;
        out_y_r     <= yo_r;
        out_front_r <= box_hit(xo_r, yo_r, front_x_r, front_y_r);
        out_back_r  <= box_hit(xo_r, yo_r, back_x_r, back_y_r);
      end else begin
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_front_r <= 1'b0;
        out_back_r  <= 1'b0;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.x_mm         = out_x_r;
  assign out_chan.y_mm         = out_y_r;
  assign out_chan.point_valid  = out_pv_r;
  assign out_chan.in_front_box = out_front_r;
  assign out_chan.in_back_box  = out_back_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_fire_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_GAIN || state_r == S_OUT))
    else $error("accepted word did not start the gain step or the output step");

  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GAIN) |=> (state_r == S_ROT && cnt_r == '0))
    else $error("rotation did not start from the first step");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pv_r) |->
      (out_x_r == '0 && out_y_r == '0 && !out_front_r && !out_back_r))
    else $error("invalid point carries coordinates or box flags");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_free) |=> (state_r == S_OUT && out_valid_r))
    else $error("finished point dropped while the output register was full");

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the polar-to-xy box filter
// Drives range samples through the sample channel, programs the registers
// through the APB-style port, and checks every point word against an
// in-bench model of the beam angle, CORDIC rotation and box tests.
// ----------------------------------------------------------------------------
module tb_top;
  import sptxy_pkg::*;

  // Rotation settings of the block under test.
  localparam int ROT_STEPS = 16;

  // Settle time after the last point, with room beyond what a valid sample takes.
  localparam int HOLD_CYCLES     = 30;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int N_BLOCKS        = 6;
  localparam int ITEMS_PER_BLOCK = 84;
  localparam int N_DIR           = 31;

  // Gain compensation 1/An in Q30.
  localparam longint GAIN_Q30_K = 64'sd652032874;

  // Arctangent of 2^-i in units of 1/2^32 turn.
  localparam longint ATAN_TABLE [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               nonfinite;
    logic               scan_start;
  } sample_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
    logic                      point_valid;
    logic                      in_front_box;
    logic                      in_back_box;
  } point_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  // One row of the directed table: either a sample word or a register write.
  // When rejected is set, the expected point is the all-zero rejected point.
  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    sample_t     smp;
    logic        rejected;
  } stim_row_t;

  localparam point_t  REJECTED_POINT = '0;
  localparam sample_t NO_SAMPLE      = '0;

  // The directed part. The first rows run with the reset settings: a range of
  // zero is not above the lower limit, 65535 is not below the upper limit, and
  // non-finite samples are always rejected. Then the four quadrants, the exact
  // range limits, a whole-plane box, empty boxes with down above up, and the
  // wrap of the beam angle past the last step of a turn.
  stim_row_t dir_rows [N_DIR] = '{
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd0, 1'b0, 1'b0}, 1'b1},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'hFFFF, 1'b0, 1'b0}, 1'b1},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd1, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'hFFFE, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd1234, 1'b1, 1'b0}, 1'b1},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'hFFFF, 1'b1, 1'b1}, 1'b1},
    '{ROW_WRITE, REG_START_ANGLE, 32'h0000_4000, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_ANGLE_STEP, 32'h0000_4000, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_RANGE_LOWER, 32'h0000_0064, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_RANGE_UPPER, 32'h0000_EA60, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_FRONT_X_WINDOW, 32'h07D0_F830, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_FRONT_Y_WINDOW, 32'h07D0_F830, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_BACK_X_WINDOW, 32'h7FFF_8000, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_BACK_Y_WINDOW, 32'hFF9C_0064, NO_SAMPLE, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd1000, 1'b0, 1'b1}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd1000, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd1000, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd1000, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd100, 1'b0, 1'b0}, 1'b1},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd60000, 1'b0, 1'b0}, 1'b1},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd101, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd59999, 1'b0, 1'b0}, 1'b0},
    '{ROW_WRITE, REG_START_ANGLE, 32'hFFFF_FFFF, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_ANGLE_STEP, 32'h0000_FFFF, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_BACK_Y_WINDOW, 32'h7FFF_8000, NO_SAMPLE, 1'b0},
    '{ROW_WRITE, REG_FRONT_X_WINDOW, 32'h0000_0001, NO_SAMPLE, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd2000, 1'b0, 1'b1}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd2000, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'h5555, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'hAAAA, 1'b0, 1'b0}, 1'b0},
    '{ROW_SAMPLE, REG_START_ANGLE, 32'h0, '{16'd59999, 1'b0, 1'b1}, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  sptxy_in_if  in_if ();
  sptxy_out_if out_if ();

  scan_polar_to_xy_box_filter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Model state: the shadow of the register file and the running beam angle.
  logic [31:0]        reg_shadow [8];
  logic [15:0]        beam_angle_q = '0;
  point_t             pending_points [$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  // Round a Q16 coordinate half up to millimetres and clamp it to 17 bits.
  function automatic logic signed [COORD_W-1:0] round_mm(input longint q);
    longint r;
    r = (q + 64'sd32768) >>> 16;
    if (r > 65535) begin
      r = 65535;
    end else if (r < -65536) begin
      r = -65536;
    end
    return r[COORD_W-1:0];
  endfunction

  // The x limits are stored negated, so x must lie in [-up, -down];
  // y must lie in [down, up]. An inverted window never matches.
  function automatic logic window_hit(input logic [31:0] xw, input logic [31:0] yw,
                                      input longint x, input longint y);
    longint xd, xu, yd, yu;
    xd = longint'($signed(xw[15:0]));
    xu = longint'($signed(xw[31:16]));
    yd = longint'($signed(yw[15:0]));
    yu = longint'($signed(yw[31:16]));
    return (x >= -xu) && (x <= -xd) && (y >= yd) && (y <= yu);
  endfunction

  // Works out the point word of one accepted sample and advances the beam angle.
  function automatic point_t project_beam(input sample_t s);
    logic [15:0]               angle;
    logic [31:0]               a32;
    longint                    x, y, z, dx, dy, t;
    logic signed [COORD_W-1:0] xm, ym;
    point_t                    p;
    angle = s.scan_start ? reg_shadow[REG_START_ANGLE][15:0] : beam_angle_q;
    beam_angle_q = angle + reg_shadow[REG_ANGLE_STEP][15:0];
    p = REJECTED_POINT;
    p.point_valid = !s.nonfinite && (s.range_mm > reg_shadow[REG_RANGE_LOWER][15:0])
                    && (s.range_mm < reg_shadow[REG_RANGE_UPPER][15:0]);
    if (p.point_valid) begin
      // The top two bits of the turn pick the quadrant; the rest is rotated.
      a32 = {angle, 16'h0000};
      z = longint'(a32[29:0]);
      x = (longint'(s.range_mm) * GAIN_Q30_K) >>> 14;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_TABLE[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_TABLE[i];
        end
      end
      case (a32[31:30])
        2'd1: begin
          t = x;
          x = -y;
          y = t;
        end
        2'd2: begin
          x = -x;
          y = -y;
        end
        2'd3: begin
          t = x;
          x = y;
          y = -t;
        end
        default: ;
      endcase
      xm = round_mm(x);
      ym = round_mm(y);
      p.x_mm = xm;
      p.y_mm = ym;
      p.in_front_box = window_hit(reg_shadow[REG_FRONT_X_WINDOW],
                                  reg_shadow[REG_FRONT_Y_WINDOW],
                                  longint'(xm), longint'(ym));
      p.in_back_box  = window_hit(reg_shadow[REG_BACK_X_WINDOW],
                                  reg_shadow[REG_BACK_Y_WINDOW],
                                  longint'(xm), longint'(ym));
    end
    return p;
  endfunction

  // Presents one sample word, with a random gap before it, and records the
  // expected point once the word is taken.
  task automatic send_sample(input sample_t s, input logic rejected);
    point_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.range_mm   <= s.range_mm;
    in_if.nonfinite  <= s.nonfinite;
    in_if.scan_start <= s.scan_start;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    p = project_beam(s);
    if (rejected) begin
      p = REJECTED_POINT;
    end
    pending_points.push_back(p);
  endtask

  // Stops the sample stream and waits until the block has gone idle.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  // One APB write followed by a read-back of the same register.
  task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    reg_shadow[idx] = (idx < REG_FRONT_X_WINDOW) ? (value & 32'h0000_FFFF) : value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (rd !== reg_shadow[idx]) begin
      note_mismatch($sformatf("register %0d read %h, expected %h", idx, rd, reg_shadow[idx]));
    end
  endtask

  // A window word for the box limits [lo, hi]; the x axis keeps them negated.
  // Some windows come out inverted and some fully random.
  function automatic logic [31:0] random_window(input logic x_axis);
    int a, b, lo, hi, r;
    r  = $urandom_range(99);
    a  = int'($urandom_range(30000)) - 15000;
    b  = int'($urandom_range(30000)) - 15000;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (r < 10) begin
      lo = hi + 1 + int'($urandom_range(200));
    end else if (r < 20) begin
      return $urandom();
    end
    return x_axis ? {16'(-lo), 16'(-hi)} : {16'(hi), 16'(lo)};
  endfunction

  // Random block settings: general ones, angle register extremes with
  // whole-plane boxes, zero and small steps, and limits rejecting every range.
  task automatic configure_block(input int blk);
    logic [31:0] v [8];
    v[REG_START_ANGLE]    = $urandom();
    v[REG_ANGLE_STEP]     = $urandom();
    v[REG_RANGE_LOWER]    = ($urandom() & 32'hFFFF_0000) | $urandom_range(2000);
    v[REG_RANGE_UPPER]    = ($urandom() & 32'hFFFF_0000) | $urandom_range(65535, 20000);
    v[REG_FRONT_X_WINDOW] = random_window(1'b1);
    v[REG_FRONT_Y_WINDOW] = random_window(1'b0);
    v[REG_BACK_X_WINDOW]  = random_window(1'b1);
    v[REG_BACK_Y_WINDOW]  = random_window(1'b0);
    case (blk)
      1: begin
        v[REG_START_ANGLE]    = 32'h0000_FFFF;
        v[REG_ANGLE_STEP]     = 32'h0000_FFFF;
        v[REG_RANGE_LOWER]    = 32'h0000_0000;
        v[REG_RANGE_UPPER]    = 32'h0000_FFFF;
        v[REG_FRONT_X_WINDOW] = 32'h7FFF_8000;
        v[REG_FRONT_Y_WINDOW] = 32'h7FFF_8000;
      end
      2: v[REG_ANGLE_STEP] = 32'h0000_0000;
      3: begin
        v[REG_RANGE_LOWER] = 32'h0000_FFFF;
        v[REG_RANGE_UPPER] = 32'h0000_0000;
      end
      4: v[REG_ANGLE_STEP] = $urandom_range(64, 1);
      default: ;
    endcase
    settle();
    for (int i = 0; i < 8; i++) begin
      program_reg(3'(i), v[i]);
    end
  endtask

  // Mostly in-range samples, many of them short so the points land in boxes;
  // the rest are non-finite, on the limits, or fully random.
  function automatic sample_t random_sample(input logic first);
    sample_t     s;
    int          r, lo, hi;
    r  = $urandom_range(99);
    lo = int'(reg_shadow[REG_RANGE_LOWER][15:0]);
    hi = int'(reg_shadow[REG_RANGE_UPPER][15:0]);
    s.range_mm   = 16'($urandom());
    s.nonfinite  = 1'b0;
    s.scan_start = first || ($urandom_range(15) == 0);
    if (r < 70 && hi > lo + 1) begin
      if (r < 50 && hi - 1 > lo + 20000) begin
        s.range_mm = 16'($urandom_range(lo + 20000, lo + 1));
      end else begin
        s.range_mm = 16'($urandom_range(hi - 1, lo + 1));
      end
    end else if (r < 80) begin
      s.nonfinite = 1'b1;
    end else if (r < 90) begin
      case ($urandom_range(3))
        0: s.range_mm = 16'd0;
        1: s.range_mm = lo[15:0];
        2: s.range_mm = hi[15:0];
        default: s.range_mm = 16'hFFFF;
      endcase
    end else if (r < 95) begin
      s.nonfinite = 1'($urandom_range(1));
    end
    return s;
  endfunction

  // Receiver: random back-pressure and the comparison of each point word with
  // the oldest expected point.
  always @(posedge clk) begin
    point_t want, got;
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.x_mm, out_if.y_mm, out_if.point_valid, out_if.in_front_box,
             out_if.in_back_box};
      if (pending_points.size() == 0) begin
        note_mismatch($sformatf("unexpected point word x=%0d y=%0d v=%b f=%b b=%b",
                                got.x_mm, got.y_mm, got.point_valid, got.in_front_box,
                                got.in_back_box));
      end else begin
        want = pending_points.pop_front();
        if (got.x_mm !== want.x_mm || got.y_mm !== want.y_mm ||
            got.point_valid !== want.point_valid ||
            got.in_front_box !== want.in_front_box ||
            got.in_back_box !== want.in_back_box) begin
          note_mismatch($sformatf(
            "point expected x=%0d y=%0d v=%b f=%b b=%b, got x=%0d y=%0d v=%b f=%b b=%b",
            want.x_mm, want.y_mm, want.point_valid, want.in_front_box, want.in_back_box,
            got.x_mm, got.y_mm, got.point_valid, got.in_front_box, got.in_back_box));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // The sample and register ports are known from time zero; the receiver
    // drives ready from the first clock edge, while reset is still held.
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.range_mm   = '0;
    in_if.nonfinite  = 1'b0;
    in_if.scan_start = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    for (int i = 0; i < 8; i++) begin
      reg_shadow[i] = '0;
    end
    reg_shadow[REG_RANGE_UPPER] = 32'h0000_FFFF;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // First the sender idles lightly and the receiver heavily.
    send_idle_pct = 17;
    recv_idle_pct = 49;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle();
        program_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].rejected);
      end
    end

    // Random blocks, two per idling pattern: then the roles swap, then no
    // idling at all.
    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      send_idle_pct = (blk < 2) ? 17 : (blk < 4) ? 49 : 0;
      recv_idle_pct = (blk < 2) ? 49 : (blk < 4) ? 17 : 0;
      configure_block(blk);
      for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
        send_sample(random_sample(n == 0), 1'b0);
      end
    end

    // Drain the last points and give the block time to emit anything stray.
    in_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
